@@ rtl/sfam_pkg.sv @@
// Shared constants, widths and the arctangent table for the field-of-view margin block.
// No dependencies; imported by sfam_cordic and sar_fov_angular_margin_core.
package sfam_pkg;

    // Payload and register widths
    localparam int IN_W       = 24;
    localparam int CFG_EL_W   = 19;
    localparam int CFG_EX_W   = 18;
    localparam int CFG_DATA_W = 19;
    localparam int CFG_IDX_W  = 2;
    localparam int MARGIN_W   = 20;

    // Angle format default (fraction bits of the output angles)
    localparam int ANGLE_FRAC_BITS_DEF = 16;

    // CORDIC datapath: operands are scaled by 2^32, plus headroom for gain and rotation
    localparam int OPERAND_SHIFT = 32;
    localparam int CORDIC_W      = IN_W + OPERAND_SHIFT + 3;
    localparam int ACC_W         = 34;
    localparam int ATAN_TAB_LEN  = 26;

    // Margin arithmetic width
    localparam int MC_W = 32;

    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint PI_Q30      = 64'sd3373259426;

    // atan(2^-i) in Q30
    localparam logic [29:0] ATAN_Q30 [0:ATAN_TAB_LEN-1] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
        30'd33543516,  30'd16775851,  30'd8388437,   30'd4194283,   30'd2097149,
        30'd1048576,   30'd524288,    30'd262144,    30'd131072,    30'd65536,
        30'd32768,     30'd16384,     30'd8192,      30'd4096,      30'd2048,
        30'd1024,      30'd512,       30'd256,       30'd128,       30'd64,
        30'd32
    };

    // Register reset values
    localparam logic signed [CFG_EL_W-1:0] MIN_EL_RST = -19'sd102944;
    localparam logic signed [CFG_EL_W-1:0] MAX_EL_RST = 19'sd102944;

    // Saturation limits of the result
    localparam logic signed [MC_W-1:0] MARGIN_LO = -32'sd524288;
    localparam logic signed [MC_W-1:0] MARGIN_HI = 32'sd524287;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_EL = 2'd0,
        REG_MAX_EL = 2'd1,
        REG_FWD_EX = 2'd2,
        REG_BWD_EX = 2'd3
    } cfg_index_t;

endpackage

@@ rtl/sar_fov_angular_margin_core.sv @@
// Top level of the field-of-view angular margin block: config registers, two CORDIC
// pipelines and the margin/minimum pipeline. Depends on sfam_pkg and sfam_cordic.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one direction vector dir_x, dir_y, dir_z
//   per request; output channel (out_valid / out_stall) carries the smallest margin.
//   Configuration is a write port (cfg_we, cfg_index, cfg_data); write it while idle.
//   A request passes one input stage, one stage per CORDIC iteration
//   (ANGLE_FRAC_BITS + 2), a rounding stage and three margin stages on its way to
//   out_valid. Throughput is one request per cycle while the receiver does not stall,
//   set by the fully unrolled CORDIC iteration pipeline.
//   When the receiver stalls a valid result, the whole pipeline holds and in_stall
//   rises in the same cycle; nothing is dropped or repeated. Bubbles do not stall.
//   Reset clears all valid bits and loads the register defaults (elevation limits
//   of about +/-1.571 rad, no exclusions).
module sar_fov_angular_margin_core #(
    parameter int ANGLE_FRAC_BITS = sfam_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  logic signed [sfam_pkg::IN_W-1:0]         dir_x,
    input  logic signed [sfam_pkg::IN_W-1:0]         dir_y,
    input  logic signed [sfam_pkg::IN_W-1:0]         dir_z,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic signed [sfam_pkg::MARGIN_W-1:0]     margin,
    input  logic                                     cfg_we,
    input  logic [sfam_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [sfam_pkg::CFG_DATA_W-1:0]          cfg_data
);
    import sfam_pkg::*;

    localparam int ITERS     = ANGLE_FRAC_BITS + 2;
    localparam int RND_SHIFT = 30 - ANGLE_FRAC_BITS;
    localparam int ANG_W     = ANGLE_FRAC_BITS + 3;
    localparam int DEPTH     = ITERS + 5;

    localparam longint KPI_L = (PI_Q30 + (64'sd1 <<< (RND_SHIFT - 1))) >>> RND_SHIFT;
    localparam logic signed [MC_W-1:0] KPI      = MC_W'(KPI_L);
    localparam logic signed [MC_W-1:0] KPI_HALF = MC_W'(KPI_L >>> 1);

    logic signed [CFG_EL_W-1:0] min_el_reg;
    logic signed [CFG_EL_W-1:0] max_el_reg;
    logic [CFG_EX_W-1:0]        fwd_ex_reg;
    logic [CFG_EX_W-1:0]        bwd_ex_reg;

    logic [DEPTH-1:0]           vld_reg;
    logic                       adv;

    logic signed [ANG_W-1:0]    elev;
    logic signed [ANG_W-1:0]    azim;

    logic signed [MC_W-1:0]     elev_e;
    logic signed [MC_W-1:0]     azim_e;
    logic signed [MC_W-1:0]     abs_az;

    logic signed [MC_W-1:0]     m_lo_reg;
    logic signed [MC_W-1:0]     m_hi_reg;
    logic signed [MC_W-1:0]     m_fwd_reg;
    logic signed [MC_W-1:0]     m_bwd_reg;
    logic signed [MC_W-1:0]     min_a_reg;
    logic signed [MC_W-1:0]     min_b_reg;
    logic signed [MC_W-1:0]     min_all;
    logic signed [MARGIN_W-1:0] margin_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_el_reg <= MIN_EL_RST;
            max_el_reg <= MAX_EL_RST;
            fwd_ex_reg <= '0;
            bwd_ex_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MIN_EL: min_el_reg <= cfg_data[CFG_EL_W-1:0];
                REG_MAX_EL: max_el_reg <= cfg_data[CFG_EL_W-1:0];
                REG_FWD_EX: fwd_ex_reg <= cfg_data[CFG_EX_W-1:0];
                REG_BWD_EX: bwd_ex_reg <= cfg_data[CFG_EX_W-1:0];
            endcase
        end
    end

    // Advance the whole pipeline unless a finished result is held by the receiver
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
        end
    end

    assign out_valid = vld_reg[DEPTH-1];

    // Elevation and azimuth
    sfam_cordic #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_elev (
        .clk   (clk),
        .en    (adv),
        .num   (dir_y),
        .den   (dir_z),
        .angle (elev)
    );

    sfam_cordic #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_azim (
        .clk   (clk),
        .en    (adv),
        .num   (dir_x),
        .den   (dir_z),
        .angle (azim)
    );

    // Form the four margins
    always_comb
    begin
        elev_e = MC_W'(elev);
        azim_e = MC_W'(azim);
        abs_az = (azim_e < 0) ? -azim_e : azim_e;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_lo_reg  <= elev_e - MC_W'(min_el_reg);
            m_hi_reg  <= MC_W'(max_el_reg) - elev_e;
            m_fwd_reg <= abs_az - MC_W'(fwd_ex_reg);
            m_bwd_reg <= (KPI - abs_az) - MC_W'(bwd_ex_reg);
        end
    end

    // Reduce pairwise
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            min_a_reg <= (m_hi_reg < m_lo_reg) ? m_hi_reg : m_lo_reg;
            min_b_reg <= (m_bwd_reg < m_fwd_reg) ? m_bwd_reg : m_fwd_reg;
        end
    end

    // Final minimum and saturation
    assign min_all = (min_b_reg < min_a_reg) ? min_b_reg : min_a_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (min_all < MARGIN_LO)
            begin
                margin_reg <= MARGIN_LO[MARGIN_W-1:0];
            end
            else if (min_all > MARGIN_HI)
            begin
                margin_reg <= MARGIN_HI[MARGIN_W-1:0];
            end
            else
            begin
                margin_reg <= min_all[MARGIN_W-1:0];
            end
        end
    end

    assign margin = margin_reg;

`ifndef ASSERT_OFF
    // Input is held back only by a stalled result
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("in_stall raised without a stalled result");

    // A held result freezes every valid bit
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(vld_reg))
        else $error("pipeline moved while output was stalled");

    // The two azimuth margins sum to at most pi, so their minimum is at most pi/2
    a_margin_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (MC_W'(margin) <= KPI_HALF))
        else $error("margin exceeds half of pi");
`endif

endmodule

@@ rtl/sfam_cordic.sv @@
// Pipelined full-circle atan2 by CORDIC vectoring, one iteration per register stage.
// Depends on sfam_pkg for widths and the arctangent table.
module sfam_cordic #(
    parameter int ANGLE_FRAC_BITS = sfam_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [sfam_pkg::IN_W-1:0]    num,
    input  logic signed [sfam_pkg::IN_W-1:0]    den,
    output logic signed [ANGLE_FRAC_BITS+2:0]   angle
);
    import sfam_pkg::*;

    localparam int ITERS     = ANGLE_FRAC_BITS + 2;
    localparam int RND_SHIFT = 30 - ANGLE_FRAC_BITS;
    localparam int ANG_W     = ANGLE_FRAC_BITS + 3;

    localparam logic signed [ACC_W-1:0] HALF_PI = ACC_W'(HALF_PI_Q30);
    localparam logic signed [ACC_W:0]   RND_HALF = (ACC_W+1)'(1) << (RND_SHIFT - 1);

    logic signed [CORDIC_W-1:0] x_reg    [0:ITERS];
    logic signed [CORDIC_W-1:0] y_reg    [0:ITERS];
    logic signed [ACC_W-1:0]    acc_reg  [0:ITERS];
    logic                       zero_reg [0:ITERS];
    logic signed [ANG_W-1:0]    angle_reg;

    logic signed [CORDIC_W-1:0] x_scaled;
    logic signed [CORDIC_W-1:0] y_scaled;
    logic signed [CORDIC_W-1:0] x_next;
    logic signed [CORDIC_W-1:0] y_next;
    logic signed [ACC_W-1:0]    acc_next;
    logic signed [ACC_W:0]      acc_rnd;

    // Scale operands and turn a vector with negative denominator into the right half-plane
    always_comb
    begin
        x_scaled = CORDIC_W'(signed'({den, {OPERAND_SHIFT{1'b0}}}));
        y_scaled = CORDIC_W'(signed'({num, {OPERAND_SHIFT{1'b0}}}));
        x_next   = x_scaled;
        y_next   = y_scaled;
        acc_next = '0;
        if (den < 0)
        begin
            if (num >= 0)
            begin
                x_next   = y_scaled;
                y_next   = -x_scaled;
                acc_next = HALF_PI;
            end
            else
            begin
                x_next   = -y_scaled;
                y_next   = x_scaled;
                acc_next = -HALF_PI;
            end
        end
    end

    // Capture the request
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= x_next;
            y_reg[0]    <= y_next;
            acc_reg[0]  <= acc_next;
            zero_reg[0] <= (num == '0) && (den == '0);
        end
    end

    // One micro-rotation per stage
    for (genvar k = 0; k < ITERS; k++)
    begin : g_iter
        localparam logic signed [ACC_W-1:0] ATAN_K = ACC_W'(ATAN_Q30[k]);
        logic signed [CORDIC_W-1:0] dx;
        logic signed [CORDIC_W-1:0] dy;

        assign dx = y_reg[k] >>> k;
        assign dy = x_reg[k] >>> k;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!y_reg[k][CORDIC_W-1])
                begin
                    x_reg[k+1]   <= x_reg[k] + dx;
                    y_reg[k+1]   <= y_reg[k] - dy;
                    acc_reg[k+1] <= acc_reg[k] + ATAN_K;
                end
                else
                begin
                    x_reg[k+1]   <= x_reg[k] - dx;
                    y_reg[k+1]   <= y_reg[k] + dy;
                    acc_reg[k+1] <= acc_reg[k] - ATAN_K;
                end
                zero_reg[k+1] <= zero_reg[k];
            end
        end
    end

    // Round Q30 to the output format, half up
    assign acc_rnd = ((ACC_W+1)'(acc_reg[ITERS]) + RND_HALF) >>> RND_SHIFT;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            angle_reg <= zero_reg[ITERS] ? '0 : acc_rnd[ANG_W-1:0];
        end
    end

    assign angle = angle_reg;

endmodule

@@ test/fov_margin_checker.sv @@
`timescale 1ns / 1ps
// Checker for sar_fov_angular_margin_core: follows register writes, predicts the margin
// of each accepted request and compares results in order. Depends on sfam_pkg.
module fov_margin_checker #(
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_stall,
    input  logic signed [sfam_pkg::IN_W-1:0]     dir_x,
    input  logic signed [sfam_pkg::IN_W-1:0]     dir_y,
    input  logic signed [sfam_pkg::IN_W-1:0]     dir_z,
    input  logic                                 out_valid,
    input  logic                                 out_stall,
    input  logic signed [sfam_pkg::MARGIN_W-1:0] margin,
    input  logic                                 cfg_we,
    input  logic [sfam_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sfam_pkg::CFG_DATA_W-1:0]      cfg_data,
    output int                                   mismatches,
    output int                                   outstanding,
    output int                                   requests_seen,
    output int                                   margins_checked
);
    import sfam_pkg::*;

    localparam int     ITERS         = ANGLE_FRAC_BITS + 2;
    localparam int     ROUND_SHIFT   = 30 - ANGLE_FRAC_BITS;
    localparam int     ARCTAN_LEN    = 26;
    localparam longint QUARTER_TURN  = 64'sd1686629713;
    localparam longint HALF_TURN     = 64'sd3373259426;
    localparam longint SAT_LO        = -64'sd524288;
    localparam longint SAT_HI        = 64'sd524287;
    localparam longint ELEV_LO_RESET = -64'sd102944;
    localparam longint ELEV_HI_RESET = 64'sd102944;

    // atan(2^-i), radians Q30
    localparam longint ARCTAN_Q30 [0:ARCTAN_LEN-1] = '{
        843314857, 497837829, 263043837, 133525159, 67021687,
        33543516,  16775851,  8388437,   4194283,   2097149,
        1048576,   524288,    262144,    131072,    65536,
        32768,     16384,     8192,      4096,      2048,
        1024,      512,       256,       128,       64,
        32
    };

    // Register copy
    longint elev_lo;
    longint elev_hi;
    longint fwd_blind;
    longint bwd_blind;

    logic signed [MARGIN_W-1:0] margin_q [$];
    int err_count;
    int req_count;
    int chk_count;

    // Round a Q30 angle to the output format, half up
    function automatic longint to_out_angle(longint a);
        return (a + (64'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
    endfunction

    // Full-circle atan2(num, den) by CORDIC vectoring
    function automatic longint vector_angle(longint num, longint den);
        longint vx;
        longint vy;
        longint t;
        longint sx;
        longint sy;
        longint acc;
        int     i;
        if (num == 0 && den == 0)
            return 0;
        vx  = den <<< 32;
        vy  = num <<< 32;
        acc = 0;
        // fold the left half plane into the right one
        if (vx < 0)
        begin
            t = vx;
            if (vy >= 0)
            begin
                vx  = vy;
                vy  = -t;
                acc = QUARTER_TURN;
            end
            else
            begin
                vx  = -vy;
                vy  = t;
                acc = -QUARTER_TURN;
            end
        end
        for (i = 0; i < ITERS && i < ARCTAN_LEN; i++)
        begin
            sx = vy >>> i;
            sy = vx >>> i;
            if (vy >= 0)
            begin
                vx  = vx + sx;
                vy  = vy - sy;
                acc = acc + ARCTAN_Q30[i];
            end
            else
            begin
                vx  = vx - sx;
                vy  = vy + sy;
                acc = acc - ARCTAN_Q30[i];
            end
        end
        return to_out_angle(acc);
    endfunction

    // Smallest of the four angular margins, saturated to the result width
    function automatic logic signed [MARGIN_W-1:0] view_margin(longint x, longint y,
                                                              longint z);
        longint el;
        longint az;
        longint abs_az;
        longint m;
        el     = vector_angle(y, z);
        az     = vector_angle(x, z);
        abs_az = (az < 0) ? -az : az;
        m = el - elev_lo;
        if (elev_hi - el < m)
            m = elev_hi - el;
        if (abs_az - fwd_blind < m)
            m = abs_az - fwd_blind;
        if (to_out_angle(HALF_TURN) - abs_az - bwd_blind < m)
            m = to_out_angle(HALF_TURN) - abs_az - bwd_blind;
        if (m < SAT_LO)
            m = SAT_LO;
        if (m > SAT_HI)
            m = SAT_HI;
        return m[MARGIN_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        logic signed [MARGIN_W-1:0] want;
        if (!rst_n)
        begin
            elev_lo   = ELEV_LO_RESET;
            elev_hi   = ELEV_HI_RESET;
            fwd_blind = 0;
            bwd_blind = 0;
            margin_q.delete();
            err_count = 0;
            req_count = 0;
            chk_count = 0;
        end
        else
        begin
            // follow register writes
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    REG_MIN_EL: elev_lo   = longint'($signed(cfg_data[CFG_EL_W-1:0]));
                    REG_MAX_EL: elev_hi   = longint'($signed(cfg_data[CFG_EL_W-1:0]));
                    REG_FWD_EX: fwd_blind = longint'(cfg_data[CFG_EX_W-1:0]);
                    REG_BWD_EX: bwd_blind = longint'(cfg_data[CFG_EX_W-1:0]);
                    default: ;
                endcase
            end
            // predict each accepted request
            if (in_valid && !in_stall)
            begin
                margin_q.push_back(view_margin(longint'(dir_x), longint'(dir_y),
                                               longint'(dir_z)));
                req_count++;
            end
            // compare each accepted result with the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (margin_q.size() == 0)
                begin
                    $error("margin: expected none, actual %0d", margin);
                    err_count++;
                end
                else
                begin
                    want = margin_q.pop_front();
                    chk_count++;
                    if (margin !== want)
                    begin
                        $error("margin: expected %0d, actual %0d", want, margin);
                        err_count++;
                    end
                end
            end
        end
        mismatches      <= err_count;
        outstanding     <= margin_q.size();
        requests_seen   <= req_count;
        margins_checked <= chk_count;
    end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// Testbench top for sar_fov_angular_margin_core: clock, reset, register settings,
// direction stimulus and receiver stalls. Depends on sfam_pkg and fov_margin_checker.
module tb;
    import sfam_pkg::*;

    localparam int     ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF;
    localparam int     LATENCY         = ANGLE_FRAC_BITS + 7;
    localparam int     SEGMENTS        = 8;
    localparam int     SEG_REQUESTS    = 236;
    localparam int     ANGLE_PI        = 205887;
    localparam longint TIMEOUT_NS      = 64'd6000000;

    localparam logic signed [IN_W-1:0] DIR_MAX = 24'sh7FFFFF;
    localparam logic signed [IN_W-1:0] DIR_MIN = 24'sh800000;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    logic signed [IN_W-1:0]       dir_x;
    logic signed [IN_W-1:0]       dir_y;
    logic signed [IN_W-1:0]       dir_z;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic signed [MARGIN_W-1:0]   margin;
    logic                         cfg_we;
    cfg_index_t                   cfg_index;
    logic [CFG_DATA_W-1:0]        cfg_data;

    int mismatches;
    int outstanding;
    int requests_seen;
    int margins_checked;
    int idle_pct  = 0;
    int stall_pct = 0;
    int settings_used;

    sar_fov_angular_margin_core #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .dir_x    (dir_x),
        .dir_y    (dir_y),
        .dir_z    (dir_z),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .margin   (margin),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    fov_margin_checker #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_margin_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .dir_x          (dir_x),
        .dir_y          (dir_y),
        .dir_z          (dir_z),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .margin         (margin),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .requests_seen  (requests_seen),
        .margins_checked(margins_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Stall the result channel at the current rate
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Hard stop
    initial
    begin
        #(TIMEOUT_NS);
        $display("sar_fov_angular_margin_core: mismatch");
        $finish;
    end

    // Offer one request, idling first at the current rate; hold until accepted
    task automatic send_dir(input logic signed [IN_W-1:0] x, input logic signed [IN_W-1:0] y,
                            input logic signed [IN_W-1:0] z);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        dir_x    <= x;
        dir_y    <= y;
        dir_z    <= z;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Drop valid and hold until every predicted margin has come back
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    task automatic set_regs(input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi,
                            input logic [CFG_DATA_W-1:0] fwd,
                            input logic [CFG_DATA_W-1:0] bwd);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MIN_EL;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= REG_MAX_EL;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_index <= REG_FWD_EX;
        cfg_data  <= fwd;
        @(posedge clk);
        cfg_index <= REG_BWD_EX;
        cfg_data  <= bwd;
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic logic signed [IN_W-1:0] pick_comp();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return DIR_MAX;
            2: return DIR_MIN;
            3: return IN_W'(int'($urandom_range(0, 32)) - 16);
            default: return IN_W'($urandom());
        endcase
    endfunction

    task automatic send_random();
        int zi;
        int xi;
        int yi;
        if ($urandom_range(0, 2) == 0)
        begin
            // point near boresight at a random scale
            zi = int'($urandom_range(1, 8388607) >> $urandom_range(0, 20));
            xi = int'($urandom_range(0, zi)) - zi / 2;
            yi = int'($urandom_range(0, zi)) - zi / 2;
            send_dir(IN_W'(xi), IN_W'(yi), IN_W'(zi));
        end
        else
        begin
            send_dir(pick_comp(), pick_comp(), pick_comp());
        end
    endtask

    task automatic send_directed();
        send_dir(0, 0, 0);
        send_dir(0, 0, 1);
        send_dir(0, 0, -1);
        send_dir(0, 0, DIR_MIN);
        send_dir(0, 0, DIR_MAX);
        send_dir(0, 1, 0);
        send_dir(0, -1, 0);
        send_dir(1, 0, 0);
        send_dir(-1, 0, 0);
        send_dir(DIR_MIN, 0, 0);
        send_dir(0, DIR_MIN, 0);
        send_dir(DIR_MAX, DIR_MAX, DIR_MAX);
        send_dir(DIR_MIN, DIR_MIN, DIR_MIN);
        send_dir(DIR_MAX, DIR_MIN, DIR_MIN);
        send_dir(DIR_MIN, DIR_MAX, 0);
        send_dir(DIR_MAX, 0, -1);
        send_dir(-1, -1, DIR_MIN);
        send_dir(1, 1, DIR_MIN);
        send_dir(DIR_MIN, DIR_MIN, DIR_MAX);
        send_dir(DIR_MAX, DIR_MAX, DIR_MIN);
        send_dir(1, -1, -1);
        send_dir(-1, 1, 1);
    endtask

    initial
    begin
        int seg;
        int k;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        dir_x         = '0;
        dir_y         = '0;
        dir_z         = '0;
        cfg_we        = 1'b0;
        cfg_index     = REG_MIN_EL;
        cfg_data      = '0;
        settings_used = 1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            // change registers only with the pipeline empty
            if (seg > 0)
            begin
                drain();
                repeat (LATENCY) @(posedge clk);
            end
            case (seg)
                1: set_regs(CFG_DATA_W'(-ANGLE_PI), CFG_DATA_W'(ANGLE_PI), '0, '0);
                2: set_regs(CFG_DATA_W'(ANGLE_PI), CFG_DATA_W'(-ANGLE_PI),
                            CFG_DATA_W'(ANGLE_PI), CFG_DATA_W'(ANGLE_PI));
                4: set_regs(CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()),
                            CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()));
                5: set_regs(19'h40000, 19'h3FFFF, 19'h7FFFF, 19'h7FFFF);
                default:
                    if (seg > 0)
                        set_regs(CFG_DATA_W'(int'($urandom_range(0, 2 * ANGLE_PI)) - ANGLE_PI),
                                 CFG_DATA_W'(int'($urandom_range(0, 2 * ANGLE_PI)) - ANGLE_PI),
                                 CFG_DATA_W'($urandom_range(0, ANGLE_PI)),
                                 CFG_DATA_W'($urandom_range(0, ANGLE_PI)));
            endcase
            // pacing: none, sender idle, receiver stalled, both
            case (seg % 4)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 87;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 87;
                end
                default:
                begin
                    idle_pct  = 32;
                    stall_pct = 32;
                end
            endcase
            if (seg == 0)
                send_directed();
            for (k = 0; k < SEG_REQUESTS; k++)
            begin
                if (k == SEG_REQUESTS / 2)
                    drain();
                send_random();
            end
        end

        drain();
        repeat (2 * LATENCY) @(posedge clk);

        $display("Sent %0d direction vectors over %0d register settings and four pacing modes;",
                 requests_seen, settings_used);
        $display("checked %0d margins, %0d mismatching.", margins_checked, mismatches);
        if (outstanding != 0)
            $error("margin: %0d expected results never arrived", outstanding);
        if (mismatches == 0 && outstanding == 0)
            $display("sar_fov_angular_margin_core: match");
        else
            $display("sar_fov_angular_margin_core: mismatch");
        $finish;
    end

endmodule
